// ===== hw/rtl/dnle_pkg.sv =====
// Shared types and constants for the DNS name label encoder.
// Used by the controller, the datapath and the top level; depends on nothing.
package dnle_pkg;

    // Size limits of a label and of a whole name.
    localparam int MAX_LABEL_BYTES = 63;
    localparam int MAX_NAME_CHARS  = 255;

    // Label store geometry and counter widths; the fill counter holds at least
    // three bits so that the top-domain positions fit.
    localparam int STORE_DEPTH = MAX_LABEL_BYTES;
    localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int FILL_W      = ($clog2(MAX_LABEL_BYTES + 1) < 3) ? 3
                                 : $clog2(MAX_LABEL_BYTES + 1);
    localparam int COUNT_W     = $clog2(MAX_NAME_CHARS + 1);

    // Special characters.
    localparam logic [7:0] CHAR_DOT = 8'h2E;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    // Lengths of the accepted top-level labels.
    localparam int LOCAL_LEN = 5;
    localparam int ARPA_LEN  = 4;

    // Status codes reported with the final transfer of a name.
    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_LABEL = 2'd1,
        ERR_TOP   = 2'd2,
        ERR_LONG  = 2'd3
    } err_code_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN,
        ST_RD,
        ST_DATA,
        ST_ERR
    } fsm_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic load_len;
        logic load_data;
        logic load_err;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic go_label;
        logic go_error;
        logic out_free;
        logic idx_last;
    } stat_t;

    // Characters of "local" by position.
    function automatic logic [7:0] local_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h6C;
            3'd1:    ch = 8'h6F;
            3'd2:    ch = 8'h63;
            3'd3:    ch = 8'h61;
            3'd4:    ch = 8'h6C;
            default: ch = CHAR_NUL;
        endcase
        return ch;
    endfunction

    // Characters of "arpa" by position.
    function automatic logic [7:0] arpa_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h61;
            3'd1:    ch = 8'h72;
            3'd2:    ch = 8'h70;
            3'd3:    ch = 8'h61;
            default: ch = CHAR_NUL;
        endcase
        return ch;
    endfunction

endpackage

// ===== hw/rtl/dnle_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependency.
module dnle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/dnle_datapath.sv =====
// Datapath of the DNS name label encoder: per-name state, label store,
// top-domain match flags and the output register. Depends on dnle_pkg and dnle_ram.
module dnle_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [7:0]      name_char,
    input  logic            char_last,
    input  dnle_pkg::cmd_t  cmd,
    output dnle_pkg::stat_t stat,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [7:0]      out_byte,
    output logic            out_last,
    output logic [1:0]      status
);
    import dnle_pkg::*;

    // Per-name state.
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    err_code_t          err_reg, err_next;
    logic               ended_reg, ended_next;
    logic               local_ok_reg, local_ok_next;
    logic               arpa_ok_reg, arpa_ok_next;

    // Emission state.
    logic [FILL_W-1:0]  emit_len_reg, emit_len_next;
    logic [FILL_W-1:0]  idx_reg, idx_next;
    logic               final_reg, final_next;
    err_code_t          err_out_reg, err_out_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               out_last_reg, out_last_next;
    logic [1:0]         status_reg, status_next;

    // Results of evaluating the offered character.
    logic [FILL_W-1:0]  fill_eval;
    logic [COUNT_W-1:0] count_eval;
    err_code_t          err_eval;
    logic               ended_eval;
    logic               local_eval;
    logic               arpa_eval;
    logic               wr_eval;
    logic               emit_mid;
    logic               emit_fin;
    logic               top_match;
    logic [7:0]         ram_rdata;

    // Evaluate one character against the current per-name state.
    always_comb
    begin
        fill_eval  = fill_reg;
        count_eval = count_reg;
        err_eval   = err_reg;
        ended_eval = ended_reg;
        local_eval = local_ok_reg;
        arpa_eval  = arpa_ok_reg;
        wr_eval    = 1'b0;
        emit_mid   = 1'b0;
        emit_fin   = 1'b0;
        if (!ended_reg)
        begin
            if (name_char == CHAR_NUL)
            begin
                ended_eval = 1'b1;
            end
            else
            begin
                // Saturating character count; the first overflow is flagged.
                if (count_reg >= COUNT_W'(MAX_NAME_CHARS))
                begin
                    if (err_reg == ERR_NONE)
                    begin
                        err_eval = ERR_LONG;
                    end
                end
                else
                begin
                    count_eval = count_reg + COUNT_W'(1);
                end
                if (err_eval == ERR_NONE)
                begin
                    if (name_char == CHAR_DOT)
                    begin
                        if (fill_reg == '0)
                        begin
                            err_eval = ERR_LABEL;
                        end
                        else if (char_last)
                        begin
                            err_eval = ERR_TOP;
                        end
                        else
                        begin
                            emit_mid = 1'b1;
                        end
                        fill_eval = '0;
                    end
                    else if (fill_reg >= FILL_W'(MAX_LABEL_BYTES))
                    begin
                        err_eval = ERR_LABEL;
                    end
                    else
                    begin
                        wr_eval   = 1'b1;
                        fill_eval = fill_reg + FILL_W'(1);
                        // Track whether the label so far spells a top domain.
                        if (fill_reg == '0)
                        begin
                            local_eval = (name_char == local_char(3'd0));
                            arpa_eval  = (name_char == arpa_char(3'd0));
                        end
                        else
                        begin
                            if (fill_reg < FILL_W'(LOCAL_LEN))
                            begin
                                local_eval = local_ok_reg &&
                                             (name_char == local_char(fill_reg[2:0]));
                            end
                            if (fill_reg < FILL_W'(ARPA_LEN))
                            begin
                                arpa_eval = arpa_ok_reg &&
                                            (name_char == arpa_char(fill_reg[2:0]));
                            end
                        end
                    end
                end
            end
        end
        top_match = ((fill_eval == FILL_W'(LOCAL_LEN)) && local_eval) ||
                    ((fill_eval == FILL_W'(ARPA_LEN)) && arpa_eval);
        // The last character closes the name.
        if (char_last && (err_eval == ERR_NONE))
        begin
            if (top_match)
            begin
                emit_fin = 1'b1;
            end
            else
            begin
                err_eval = ERR_TOP;
            end
        end
    end

    // Status toward the controller.
    always_comb
    begin
        stat.go_label = emit_mid || emit_fin;
        stat.go_error = char_last && (err_eval != ERR_NONE);
        stat.out_free = !out_valid_reg || !out_stall;
        stat.idx_last = (idx_reg == (emit_len_reg - FILL_W'(1)));
    end

    // Per-name and emission state updates.
    always_comb
    begin
        fill_next     = fill_reg;
        count_next    = count_reg;
        err_next      = err_reg;
        ended_next    = ended_reg;
        local_ok_next = local_ok_reg;
        arpa_ok_next  = arpa_ok_reg;
        emit_len_next = emit_len_reg;
        idx_next      = idx_reg;
        final_next    = final_reg;
        err_out_next  = err_out_reg;
        if (cmd.accept)
        begin
            local_ok_next = local_eval;
            arpa_ok_next  = arpa_eval;
            emit_len_next = emit_mid ? fill_reg : fill_eval;
            idx_next      = '0;
            final_next    = emit_fin;
            err_out_next  = err_eval;
            if (char_last)
            begin
                fill_next  = '0;
                count_next = '0;
                err_next   = ERR_NONE;
                ended_next = 1'b0;
            end
            else
            begin
                fill_next  = fill_eval;
                count_next = count_eval;
                err_next   = err_eval;
                ended_next = ended_eval;
            end
        end
        else if (cmd.load_data)
        begin
            idx_next = idx_reg + FILL_W'(1);
        end
    end

    // Output register: loaded by the controller, emptied by a transfer.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        status_next    = status_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_len)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = 8'(emit_len_reg);
            out_last_next  = 1'b0;
            status_next    = ERR_NONE;
        end
        else if (cmd.load_data)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = ram_rdata;
            out_last_next  = final_reg && stat.idx_last;
            status_next    = ERR_NONE;
        end
        else if (cmd.load_err)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = CHAR_NUL;
            out_last_next  = 1'b1;
            status_next    = err_out_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            count_reg     <= '0;
            err_reg       <= ERR_NONE;
            ended_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            ended_reg     <= ended_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        local_ok_reg <= local_ok_next;
        arpa_ok_reg  <= arpa_ok_next;
        emit_len_reg <= emit_len_next;
        idx_reg      <= idx_next;
        final_reg    <= final_next;
        err_out_reg  <= err_out_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        status_reg   <= status_next;
    end

    // Label store: written as characters arrive, read back during emission.
    dnle_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.accept && wr_eval),
        .waddr (fill_reg[STORE_AW-1:0]),
        .wdata (name_char),
        .raddr (idx_reg[STORE_AW-1:0]),
        .rdata (ram_rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign status    = status_reg;

endmodule

// ===== hw/rtl/dnle_ctrl.sv =====
// Controller of the DNS name label encoder: accepts characters and sequences
// label and error emission. Depends on dnle_pkg.
module dnle_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  dnle_pkg::stat_t stat,
    output dnle_pkg::cmd_t  cmd
);
    import dnle_pkg::*;

    fsm_state_t state_reg, state_next;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && stat.go_label)
                begin
                    state_next = ST_LEN;
                end
                else if (in_valid && stat.go_error)
                begin
                    state_next = ST_ERR;
                end
            end
            ST_LEN:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_DATA;
            end
            ST_DATA:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.idx_last ? ST_IDLE : ST_RD;
                end
            end
            ST_ERR:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Command outputs.
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            ST_LEN:
            begin
                cmd.load_len = stat.out_free;
            end
            ST_DATA:
            begin
                cmd.load_data = stat.out_free;
            end
            ST_ERR:
            begin
                cmd.load_err = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/dns_name_label_encoder.sv =====
// Top level of the DNS name label encoder: controller, datapath and checks.
// Depends on dnle_pkg, dnle_ctrl and dnle_datapath (which holds dnle_ram).
//
// Usage: the input channel (in_valid, in_stall, name_char, char_last) takes a
// dotted name one character per transfer, char_last marking its final
// character. A zero character ends the name early; later characters up to
// char_last are ignored. The output channel (out_valid, out_stall, out_byte,
// out_last, status) gives DNS wire-format labels: a length byte, then the
// label's bytes. out_last marks the final transfer of a name, and status on it
// reports 0 ok, 1 bad label length, 2 bad top domain, 3 name too long. An
// error ends the name with one byte of zero and out_last set, after any labels
// already sent. Timing: a character that closes nothing does not hold the input
// off. A closing transfer holds the input off while the label is sent: the
// length byte is loaded, then each byte is read from the label store and loaded
// into the output register. An error result holds it off while the zero byte is
// loaded. The controller's state register and then the output register lie
// between the sides, so results are registered.
// A stalled receiver holds the output register and with it the sequencer.
// Reset clears the per-name state and empties the output register.
module dns_name_label_encoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] name_char,
    input  logic       char_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic [1:0] status
);
    import dnle_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    dnle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    dnle_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .name_char (name_char),
        .char_last (char_last),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .status    (status)
    );

    // At most one output load per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_len, cmd.load_data, cmd.load_err}))
        else $error("more than one output load in a cycle");

    // A load never overwrites a result that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_len || cmd.load_data || cmd.load_err) |-> (!out_valid || !out_stall))
        else $error("output register overwritten while stalled");

    // An accepted item that starts emission holds the input off next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && (stat.go_label || stat.go_error)) |=> in_stall)
        else $error("input not held off during emission");

    // An error result carries a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_last && (status != ERR_NONE)) |-> (out_byte == CHAR_NUL))
        else $error("error result with nonzero byte");

endmodule

// ===== dv/dns_name_label_encoder_test.sv =====
// Testbench for dns_name_label_encoder: random and directed dotted names in,
// wire-format label bytes out, checked against an in-bench label predictor.
// Depends on dnle_pkg and the encoder RTL only.
`timescale 1ns / 1ps

module dns_name_label_encoder_test;

    import dnle_pkg::*;

    // One character on the way in, and one encoded byte on the way out.
    typedef struct {
        logic [7:0] ch;
        logic       last;
        bit         hold;
    } char_item_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
        err_code_t  code;
    } wire_byte_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] name_char = 8'h00;
    logic       char_last = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       out_last;
    logic [1:0] status;

    dns_name_label_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .name_char (name_char),
        .char_last (char_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .status    (status)
    );

    // Free-running clock, 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Characters waiting to be sent, and bytes the encoder still owes.
    char_item_t chars_pending[$];
    wire_byte_t bytes_due[$];
    logic [7:0] name_buf[$];

    int results_due  = 0;
    int results_seen = 0;
    int fail_count   = 0;
    int names_sent   = 0;
    int chars_sent   = 0;
    int status_tally[4] = '{0, 0, 0, 0};
    int cycle_no     = 0;
    bit quiet;

    // Predictor state: the open label and the per-name bookkeeping.
    logic [7:0] label_buf[MAX_LABEL_BYTES];
    int         buf_fill   = 0;
    int         char_count = 0;
    err_code_t  name_err   = ERR_NONE;
    bit         name_done  = 1'b0;

    // Both sides run without idling for a long stretch in the middle.
    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
    end

    assign quiet = (cycle_no >= 1500) && (cycle_no < 2500);

    task automatic owe_byte(logic [7:0] data, logic last, err_code_t code);
        wire_byte_t wb;
        wb.data = data;
        wb.last = last;
        wb.code = code;
        bytes_due.push_back(wb);
        results_due++;
    endtask

    // A length byte followed by the label's bytes; optionally the name's end.
    task automatic owe_label(bit ends_name);
        owe_byte(8'(buf_fill), ends_name && (buf_fill == 0), ERR_NONE);
        for (int i = 0; i < buf_fill; i++)
        begin
            owe_byte(label_buf[i], ends_name && (i + 1 == buf_fill), ERR_NONE);
        end
    endtask

    function automatic bit label_matches(string word);
        if (buf_fill != word.len())
            return 1'b0;
        for (int i = 0; i < buf_fill; i++)
        begin
            if (label_buf[i] != word[i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Works out the bytes that one accepted character causes.
    task automatic encode_char(logic [7:0] c, logic last);
        if (!name_done)
        begin
            if (c == CHAR_NUL)
                name_done = 1'b1;
            else
            begin
                if (char_count >= MAX_NAME_CHARS)
                begin
                    if (name_err == ERR_NONE)
                        name_err = ERR_LONG;
                end
                else
                    char_count++;
                if (name_err == ERR_NONE)
                begin
                    if (c == CHAR_DOT)
                    begin
                        if (buf_fill == 0)
                            name_err = ERR_LABEL;
                        else if (last)
                            name_err = ERR_TOP;
                        else
                            owe_label(1'b0);
                        buf_fill = 0;
                    end
                    else if (buf_fill >= MAX_LABEL_BYTES)
                        name_err = ERR_LABEL;
                    else
                    begin
                        label_buf[buf_fill] = c;
                        buf_fill++;
                    end
                end
            end
        end
        if (last)
        begin
            if (name_err == ERR_NONE)
            begin
                if (label_matches("local") || label_matches("arpa"))
                    owe_label(1'b1);
                else
                    name_err = ERR_TOP;
            end
            if (name_err != ERR_NONE)
                owe_byte(8'h00, 1'b1, name_err);
            buf_fill   = 0;
            char_count = 0;
            name_err   = ERR_NONE;
            name_done  = 1'b0;
        end
    endtask

    // Input side: predict each transfer, then offer the next character.
    always @(posedge clk or negedge rst_n)
    begin
        char_item_t item;
        int         outstanding;
        bit         idle;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            name_char <= 8'h00;
            char_last <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                encode_char(name_char, char_last);
                chars_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                outstanding = results_due - results_seen - ((out_valid && !out_stall) ? 1 : 0);
                idle = !quiet && ($urandom_range(99) < 20);
                if (chars_pending.size() > 0 && !idle &&
                    (!chars_pending[0].hold || outstanding == 0))
                begin
                    item = chars_pending.pop_front();
                    in_valid  <= 1'b1;
                    name_char <= item.ch;
                    char_last <= item.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output side: random stalls, and each transfer checked in order.
    always @(posedge clk or negedge rst_n)
    begin
        wire_byte_t wb;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                if (out_last)
                    status_tally[status]++;
                if (bytes_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected transfer: out_byte %0d out_last %0d status %0d",
                             $time, out_byte, out_last, status);
                end
                else
                begin
                    wb = bytes_due.pop_front();
                    if (out_byte !== wb.data)
                    begin
                        fail_count++;
                        $display("%0t: out_byte mismatch: expected %0d, actual %0d",
                                 $time, wb.data, out_byte);
                    end
                    if (out_last !== wb.last)
                    begin
                        fail_count++;
                        $display("%0t: out_last mismatch: expected %0d, actual %0d",
                                 $time, wb.last, out_last);
                    end
                    if (status !== wb.code)
                    begin
                        fail_count++;
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, wb.code, status);
                    end
                end
            end
            out_stall <= !quiet && ($urandom_range(99) < 20);
        end
    end

    // A random label character: anything but a dot or a zero.
    function automatic logic [7:0] label_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255, 1));
        while (c == CHAR_DOT);
        return c;
    endfunction

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            name_buf.push_back(8'(s[i]));
    endtask

    task automatic add_label(int n);
        for (int i = 0; i < n; i++)
            name_buf.push_back(label_char());
    endtask

    task automatic add_top();
        if ($urandom_range(1))
            add_text("local");
        else
            add_text("arpa");
    endtask

    // Queues the built name, marking its final character; returns the number
    // of characters that the encoder does not skip.
    task automatic send_name(bit hold, output int counted);
        char_item_t item;
        bit         ended;
        counted = 0;
        ended   = 1'b0;
        for (int i = 0; i < name_buf.size(); i++)
        begin
            item.ch   = name_buf[i];
            item.last = (i + 1 == name_buf.size());
            item.hold = hold && (i == 0);
            chars_pending.push_back(item);
            if (!ended)
                counted++;
            if (name_buf[i] == CHAR_NUL)
                ended = 1'b1;
        end
        name_buf.delete();
        names_sent++;
    endtask

    // Reset, stimulus, and the wait for the last result.
    initial
    begin
        int counted;
        int random_chars;
        int name_no;
        int r;
        bit hold;

        // Short directed names: an extreme character, a name with no dot,
        // an empty label, a dot marked last, an empty name, an early zero.
        name_buf.push_back(8'hFF);
        add_text(".local");
        send_name(1'b0, counted);
        add_text("arpa");
        send_name(1'b0, counted);
        add_text(".arpa");
        send_name(1'b0, counted);
        add_text("a.");
        send_name(1'b0, counted);
        name_buf.push_back(CHAR_NUL);
        send_name(1'b0, counted);
        add_text("arpa");
        name_buf.push_back(CHAR_NUL);
        name_buf.push_back(8'h80);
        send_name(1'b0, counted);

        // The directed names count toward the character budget.
        random_chars = chars_pending.size();
        name_no = 0;
        while (random_chars < 210)
        begin
            hold = (name_no == 0) || ($urandom_range(19) == 0);
            r = $urandom_range(99);
            if (name_no == 3)
            begin
                // Too long: valid labels past the character limit. This name
                // alone is longer than the budget, so it stays outside it.
                while (name_buf.size() < MAX_NAME_CHARS + 4)
                begin
                    add_label($urandom_range(MAX_LABEL_BYTES, 40));
                    name_buf.push_back(CHAR_DOT);
                end
                add_top();
                send_name(hold, counted);
            end
            else if (name_no == 8)
            begin
                // One byte past the longest label.
                add_label(MAX_LABEL_BYTES + 1);
                add_text(".arpa");
                send_name(hold, counted);
                random_chars += counted;
            end
            else if (name_no == 13)
            begin
                // The longest label that is still legal.
                add_label(MAX_LABEL_BYTES);
                name_buf.push_back(CHAR_DOT);
                add_top();
                send_name(hold, counted);
                random_chars += counted;
            end
            else
            begin
                if (r < 55)
                begin
                    // Well-formed name with random labels.
                    repeat ($urandom_range(3))
                    begin
                        add_label(($urandom_range(9) == 0) ? $urandom_range(20, 1)
                                                           : $urandom_range(8, 1));
                        name_buf.push_back(CHAR_DOT);
                    end
                    add_top();
                end
                else if (r < 63)
                begin
                    // Wrong top-level label.
                    add_label($urandom_range(3, 1));
                    name_buf.push_back(CHAR_DOT);
                    add_label($urandom_range(6, 1));
                end
                else if (r < 70)
                begin
                    // Near misses of the accepted top-level labels.
                    add_label($urandom_range(4, 1));
                    name_buf.push_back(CHAR_DOT);
                    case ($urandom_range(3))
                        0:       add_text("Local");
                        1:       add_text("arp");
                        2:       add_text("arpaa");
                        default: add_text("locaL");
                    endcase
                end
                else if (r < 76)
                begin
                    // Empty label somewhere in the name.
                    if ($urandom_range(1))
                        add_label($urandom_range(4, 1));
                    name_buf.push_back(CHAR_DOT);
                    name_buf.push_back(CHAR_DOT);
                    add_top();
                end
                else if (r < 81)
                begin
                    // Name that ends with a dot.
                    add_label($urandom_range(4, 1));
                    name_buf.push_back(CHAR_DOT);
                    add_top();
                    name_buf.push_back(CHAR_DOT);
                end
                else if (r < 90)
                begin
                    // Zero ends the name, then skipped characters.
                    if ($urandom_range(1))
                    begin
                        add_label($urandom_range(3, 1));
                        name_buf.push_back(CHAR_DOT);
                        add_top();
                    end
                    else
                        add_label($urandom_range(3));
                    name_buf.push_back(CHAR_NUL);
                    repeat ($urandom_range(3))
                        name_buf.push_back(8'($urandom_range(255)));
                end
                else
                begin
                    // Noise: any characters at all.
                    repeat ($urandom_range(6, 1))
                        name_buf.push_back(8'($urandom_range(255)));
                end
                send_name(hold, counted);
                random_chars += counted;
            end
            name_no++;
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        do
            @(negedge clk);
        while (chars_pending.size() != 0 || in_valid || results_due != results_seen);
        repeat (150) @(posedge clk);

        $display("Sent %0d names in %0d characters; checked %0d bytes.",
                 names_sent, chars_sent, results_seen);
        $display("Name endings by status: ok %0d, label %0d, top %0d, too long %0d.",
                 status_tally[ERR_NONE], status_tally[ERR_LABEL],
                 status_tally[ERR_TOP], status_tally[ERR_LONG]);
        if (fail_count == 0 && bytes_due.size() == 0)
            $display("Simulation PASSED");
        else
        begin
            if (bytes_due.size() != 0)
                $display("%0t: %0d expected bytes never arrived", $time, bytes_due.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #10ms;
        $display("%0t: timeout", $time);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
